// ===== design/bmp_header_parse_and_pixel_address_top_assert.svh =====
// Assertion macros for the BMP header parser checker.
// Used by bhp_checker only; needs nothing else.
`ifndef BMP_HEADER_PARSE_AND_PIXEL_ADDRESS_TOP_ASSERT_SVH
`define BMP_HEADER_PARSE_AND_PIXEL_ADDRESS_TOP_ASSERT_SVH

// same-cycle implication, masked during reset
`define BHP_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define BHP_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

// next-cycle implication, always active
`define BHP_ASSERT_RAW(lbl, clk_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bhp_pkg.sv =====
// Package for the BMP header parser: constants, codes and the queue entry type.
// No dependencies.
`timescale 1ns / 1ps

package bhp_pkg;

  localparam int FILE_HDR_BYTES = 14;
  localparam int INFO_HDR_BYTES = 40;

  localparam logic [5:0] POS_FILE_LAST = 6'(FILE_HDR_BYTES - 1);
  localparam logic [5:0] POS_INFO_LAST = 6'(FILE_HDR_BYTES + INFO_HDR_BYTES - 1);
  localparam logic [5:0] HDR_BYTES     = 6'(FILE_HDR_BYTES + INFO_HDR_BYTES);

  // byte positions of header fields
  localparam logic [5:0] OFS_SIG    = 6'd0;
  localparam logic [5:0] OFS_DATA   = 6'd10;
  localparam logic [5:0] OFS_DIB    = 6'(FILE_HDR_BYTES);
  localparam logic [5:0] OFS_WIDTH  = 6'(FILE_HDR_BYTES + 4);
  localparam logic [5:0] OFS_HEIGHT = 6'(FILE_HDR_BYTES + 8);
  localparam logic [5:0] OFS_BPP    = 6'(FILE_HDR_BYTES + 14);
  localparam logic [5:0] OFS_COMP   = 6'(FILE_HDR_BYTES + 16);
  localparam logic [5:0] OFS_ISIZE  = 6'(FILE_HDR_BYTES + 20);

  localparam logic [15:0] SIG_BM       = 16'h4D42;
  localparam logic [15:0] BPP_24       = 16'd24;
  localparam logic [31:0] MIN_DIB_SIZE = 32'(INFO_HDR_BYTES);

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_FILE = 2'd1;
  localparam logic [1:0] ST_BAD_INFO = 2'd2;

  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_PIX = 1'b1;

  localparam logic [1:0] REG_MAX_WIDTH  = 2'd0;
  localparam logic [1:0] REG_MAX_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MAX_ISIZE  = 2'd2;

  localparam logic [15:0] RST_MAX_WIDTH  = 16'd1024;
  localparam logic [15:0] RST_MAX_HEIGHT = 16'd1024;
  localparam logic [31:0] RST_MAX_ISIZE  = 32'd1048576;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] width;
    logic [15:0] height;
    logic [17:0] row_bytes;
    logic [1:0]  padding;
    logic [31:0] data_offset;
    logic [31:0] image_size;
    logic [15:0] x_coord;
    logic [15:0] y_coord;
    logic [17:0] stride;
  } bhp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } bhp_qstat_t;

endpackage

// ===== design/bhp_front.sv =====
// Front end: input transfer, header byte parsing, verdict and query classification.
// Depends on bhp_pkg; feeds bhp_queue.
`timescale 1ns / 1ps

module bhp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [47:0]         s_tdata,
  input  logic                s_tuser,
  input  bhp_pkg::bhp_qstat_t qstat,
  output logic                push,
  output bhp_pkg::bhp_entry_t entry
);

  function automatic logic [31:0] put4(input logic [31:0] f, input logic [5:0] pos,
                                       input logic [5:0] start, input logic [7:0] b);
    logic [5:0]  rel;
    logic [31:0] r;
    rel = pos - start;
    r   = f;
    if (pos >= start && rel < 6'd4) r[{rel[1:0], 3'b000} +: 8] = b;
    return r;
  endfunction

  function automatic logic [15:0] put2(input logic [15:0] f, input logic [5:0] pos,
                                       input logic [5:0] start, input logic [7:0] b);
    logic [5:0]  rel;
    logic [15:0] r;
    rel = pos - start;
    r   = f;
    if (pos >= start && rel < 6'd2) r[{rel[0], 3'b000} +: 8] = b;
    return r;
  endfunction

  logic [15:0] max_width, max_height;
  logic [31:0] max_isize;

  logic [5:0]  byte_count;
  logic        header_failed;
  logic [15:0] signature, bits_per_pixel;
  logic [31:0] pixel_data_offset, dib_header_size, raw_width, raw_height;
  logic [31:0] compression_code, image_size_reg;
  logic [17:0] row_bytes_reg;

  logic [5:0]  byte_count_next;
  logic        header_failed_next;
  logic [15:0] signature_next, bits_per_pixel_next;
  logic [31:0] pixel_data_offset_next, dib_header_size_next, raw_width_next;
  logic [31:0] raw_height_next, compression_code_next, image_size_reg_next;
  logic [17:0] row_bytes_reg_next;

  logic        s_xfer, hdr_xfer, qry_xfer, restart, take;
  logic [7:0]  b;
  logic [5:0]  pos;
  logic        fail_file, at_info_end, bad_info;
  logic [31:0] abs_w, abs_h;
  logic [17:0] raw3, row_calc;
  logic [1:0]  pad;

  assign s_tready = !qstat.full;
  assign s_xfer   = s_tvalid && s_tready;
  assign hdr_xfer = s_xfer && (s_tuser == bhp_pkg::KIND_HDR);
  assign qry_xfer = s_xfer && (s_tuser == bhp_pkg::KIND_PIX);
  assign b        = s_tdata[7:0];
  assign restart  = hdr_xfer && s_tdata[8];
  assign pos      = restart ? 6'd0 : byte_count;
  assign take     = hdr_xfer && !(header_failed && !restart) && pos < bhp_pkg::HDR_BYTES;

  // at the last byte of either header all checked fields are already registered
  assign fail_file   = take && pos == bhp_pkg::POS_FILE_LAST && signature != bhp_pkg::SIG_BM;
  assign at_info_end = take && pos == bhp_pkg::POS_INFO_LAST;

  assign abs_w = raw_width[31]  ? (32'd0 - raw_width)  : raw_width;
  assign abs_h = raw_height[31] ? (32'd0 - raw_height) : raw_height;
  assign bad_info = dib_header_size < bhp_pkg::MIN_DIB_SIZE ||
                    abs_w > {16'd0, max_width} || abs_h > {16'd0, max_height} ||
                    image_size_reg > max_isize || bits_per_pixel != bhp_pkg::BPP_24 ||
                    compression_code != 32'd0;
  assign raw3     = {1'b0, abs_w[15:0], 1'b0} + {2'b00, abs_w[15:0]};
  assign pad      = 2'd0 - raw3[1:0];
  assign row_calc = raw3 + {16'd0, pad};

  always_comb begin
    signature_next         = restart ? 16'd0 : signature;
    bits_per_pixel_next    = restart ? 16'd0 : bits_per_pixel;
    pixel_data_offset_next = restart ? 32'd0 : pixel_data_offset;
    dib_header_size_next   = restart ? 32'd0 : dib_header_size;
    raw_width_next         = restart ? 32'd0 : raw_width;
    raw_height_next        = restart ? 32'd0 : raw_height;
    compression_code_next  = restart ? 32'd0 : compression_code;
    image_size_reg_next    = restart ? 32'd0 : image_size_reg;
    row_bytes_reg_next     = restart ? 18'd0 : row_bytes_reg;
    header_failed_next     = restart ? 1'b0 : header_failed;
    byte_count_next        = pos;
    if (take) begin
      signature_next         = put2(signature_next, pos, bhp_pkg::OFS_SIG, b);
      pixel_data_offset_next = put4(pixel_data_offset_next, pos, bhp_pkg::OFS_DATA, b);
      dib_header_size_next   = put4(dib_header_size_next, pos, bhp_pkg::OFS_DIB, b);
      raw_width_next         = put4(raw_width_next, pos, bhp_pkg::OFS_WIDTH, b);
      raw_height_next        = put4(raw_height_next, pos, bhp_pkg::OFS_HEIGHT, b);
      bits_per_pixel_next    = put2(bits_per_pixel_next, pos, bhp_pkg::OFS_BPP, b);
      compression_code_next  = put4(compression_code_next, pos, bhp_pkg::OFS_COMP, b);
      image_size_reg_next    = put4(image_size_reg_next, pos, bhp_pkg::OFS_ISIZE, b);
      byte_count_next        = pos + 6'd1;
      if (fail_file) header_failed_next = 1'b1;
      if (at_info_end && !bad_info) row_bytes_reg_next = row_calc;
    end
  end

  always_comb begin
    entry      = '0;
    push       = qry_xfer || fail_file || at_info_end;
    entry.kind = qry_xfer ? bhp_pkg::KIND_PIX : bhp_pkg::KIND_HDR;
    if (qry_xfer) begin
      entry.x_coord = s_tdata[24:9];
      entry.y_coord = s_tdata[40:25];
      entry.stride  = row_bytes_reg;
    end else if (fail_file) begin
      entry.status      = bhp_pkg::ST_BAD_FILE;
      entry.data_offset = {b, pixel_data_offset[23:0]};
    end else begin
      entry.status      = bad_info ? bhp_pkg::ST_BAD_INFO : bhp_pkg::ST_OK;
      entry.data_offset = pixel_data_offset;
      entry.image_size  = image_size_reg;
      if (!bad_info) begin
        entry.width     = abs_w[15:0];
        entry.height    = abs_h[15:0];
        entry.row_bytes = row_calc;
        entry.padding   = pad;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_width         <= bhp_pkg::RST_MAX_WIDTH;
      max_height        <= bhp_pkg::RST_MAX_HEIGHT;
      max_isize         <= bhp_pkg::RST_MAX_ISIZE;
      byte_count        <= 6'd0;
      header_failed     <= 1'b0;
      signature         <= 16'd0;
      bits_per_pixel    <= 16'd0;
      pixel_data_offset <= 32'd0;
      dib_header_size   <= 32'd0;
      raw_width         <= 32'd0;
      raw_height        <= 32'd0;
      compression_code  <= 32'd0;
      image_size_reg    <= 32'd0;
      row_bytes_reg     <= 18'd0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          bhp_pkg::REG_MAX_WIDTH:  max_width  <= cfg_data[15:0];
          bhp_pkg::REG_MAX_HEIGHT: max_height <= cfg_data[15:0];
          bhp_pkg::REG_MAX_ISIZE:  max_isize  <= cfg_data;
          default: ;
        endcase
      end
      if (hdr_xfer) begin
        byte_count        <= byte_count_next;
        header_failed     <= header_failed_next;
        signature         <= signature_next;
        bits_per_pixel    <= bits_per_pixel_next;
        pixel_data_offset <= pixel_data_offset_next;
        dib_header_size   <= dib_header_size_next;
        raw_width         <= raw_width_next;
        raw_height        <= raw_height_next;
        compression_code  <= compression_code_next;
        image_size_reg    <= image_size_reg_next;
        row_bytes_reg     <= row_bytes_reg_next;
      end
    end
  end

endmodule

// ===== design/bhp_queue.sv =====
// Small flop-based queue of result entries between front and back end.
// Depends on bhp_pkg.
`timescale 1ns / 1ps

module bhp_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bhp_pkg::bhp_entry_t wr_entry,
  input  logic                pop,
  output bhp_pkg::bhp_entry_t rd_entry,
  output bhp_pkg::bhp_qstat_t qstat
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  bhp_pkg::bhp_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign qstat.full  = count == CW'(DEPTH);
  assign qstat.empty = count == CW'(0);
  assign rd_entry    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

// ===== design/bhp_back.sv =====
// Back end: pixel offset multiply-add and the output register of the result stream.
// Depends on bhp_pkg; drains bhp_queue.
`timescale 1ns / 1ps

module bhp_back (
  input  logic                clk,
  input  logic                rst,
  input  bhp_pkg::bhp_entry_t head,
  input  bhp_pkg::bhp_qstat_t qstat,
  output logic                pop,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [151:0]        m_tdata,
  output logic                m_tuser
);

  logic [33:0] prod, pix;
  logic [17:0] x3;
  logic        m_tvalid_next;

  assign prod = head.stride * head.y_coord;
  assign x3   = {1'b0, head.x_coord, 1'b0} + {2'b00, head.x_coord};
  assign pix  = (head.kind == bhp_pkg::KIND_PIX) ? prod + {16'd0, x3} : 34'd0;

  assign pop           = !qstat.empty && (!m_tvalid || m_tready);
  assign m_tvalid_next = pop || (m_tvalid && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else m_tvalid <= m_tvalid_next;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tuser <= head.kind;
      m_tdata <= {pix, head.image_size, head.data_offset, head.padding, head.row_bytes,
                  head.height, head.width, head.status};
    end
  end

endmodule

// ===== design/bmp_header_parse_and_pixel_address_top.sv =====
// BMP header parser and 24-bit pixel addresser, top level.
// Depends on bhp_pkg, bhp_front, bhp_queue and bhp_back.
//
// Input stream s_*: s_tuser low carries a header byte (first_byte restarts
// parsing), s_tuser high a pixel address query. Header bytes give a verdict
// after byte 14 only if the signature is not 'BM', and after byte 54 if it is;
// other bytes give no result. A query always gives one result, 3*x plus the
// row stride of the last good header since reset or restart (else zero) times y.
// Output stream m_*: m_tuser low is a header verdict, high a pixel address.
// Config port cfg_*: index 0 max width, 1 max height, 2 max image size;
// cfg_ready is always high; writes must go in while the block is idle, which the
// block does not enforce. With the queue empty, a result passes the queue slot
// and then the output register before m_tvalid shows it. Throughput: one input
// item per cycle while the queue is not full; the pixel 18x16 multiply sits in
// the output stage. Reset clears the parse state and the row stride, loads the
// default limits and empties the queue and the output register.
// When the receiver stalls, up to QUEUE_DEPTH results wait in the queue
// behind the output register; s_tready drops only when the queue is full.
`timescale 1ns / 1ps

module bmp_header_parse_and_pixel_address_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // data_byte[7:0], first_byte[8], x_coord[24:9], y_coord[40:25], zero[47:41]
  input  logic [47:0]  s_tdata,
  // req_type[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[1:0], width[17:2], height[33:18], row_bytes[51:34], padding[53:52],
  // data_offset[85:54], image_size[117:86], pixel_offset[151:118]
  output logic [151:0] m_tdata,
  // result_kind[0]
  output logic         m_tuser
);

  bhp_pkg::bhp_entry_t wr_entry, rd_entry;
  bhp_pkg::bhp_qstat_t qstat;
  logic                push, pop;

  assign cfg_ready = 1'b1;

  bhp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .qstat     (qstat),
    .push      (push),
    .entry     (wr_entry)
  );

  bhp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .qstat    (qstat)
  );

  bhp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (rd_entry),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== design/bhp_checker.sv =====
// Port-level checker for the BMP header parser, bound to the top level.
// Depends on bmp_header_parse_and_pixel_address_top_assert.svh.
`timescale 1ns / 1ps
`include "bmp_header_parse_and_pixel_address_top_assert.svh"

module bhp_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [151:0] m_tdata,
  input logic         m_tuser
);

  `BHP_ASSERT_RAW(a_rst_empty, clk, rst, !m_tvalid, "output valid right after reset")
  `BHP_ASSERT_NXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled transfer changed")
  `BHP_ASSERT_IMP(a_pix_fields, clk, rst, m_tvalid && m_tuser, m_tdata[117:0] == 118'd0, "pixel result carries header fields")
  `BHP_ASSERT_IMP(a_hdr_fields, clk, rst, m_tvalid && !m_tuser, m_tdata[151:118] == 34'd0 && (m_tdata[1:0] == 2'd0 || m_tdata[53:2] == 52'd0), "verdict fields inconsistent")
  `BHP_ASSERT_IMP(a_row_align, clk, rst, m_tvalid && !m_tuser, m_tdata[35:34] == 2'd0, "row stride not 4-byte aligned")

endmodule

bind bmp_header_parse_and_pixel_address_top bhp_checker u_bhp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/tb_bmp_header_parse_and_pixel_address_top.sv =====
// Self-checking testbench for bmp_header_parse_and_pixel_address_top: streams BMP headers,
// pixel queries and limit writes, and scores every result against an in-bench predictor.
// Depends on bhp_pkg and the RTL of the top level.
`timescale 1ns / 1ps

module tb_bmp_header_parse_and_pixel_address_top;

  localparam int HDR_LEN     = bhp_pkg::FILE_HDR_BYTES + bhp_pkg::INFO_HDR_BYTES;
  localparam int SETTLE      = 6;
  localparam int HOLD_CYCLES = 400;
  localparam int LIMIT       = 200000;
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef enum int {
    DEF_NONE, DEF_SIG, DEF_DIB, DEF_WIDTH, DEF_HEIGHT, DEF_ISIZE, DEF_BPP, DEF_COMP, DEF_TRUNC
  } defect_t;

  // laid out as {m_tuser, m_tdata}
  typedef struct packed {
    logic        kind;
    logic [33:0] pixel_offset;
    logic [31:0] image_size;
    logic [31:0] data_offset;
    logic [1:0]  padding;
    logic [17:0] row_bytes;
    logic [15:0] height;
    logic [15:0] width;
    logic [1:0]  status;
  } result_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [47:0]  s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [151:0] m_tdata;
  logic         m_tuser;

  bmp_header_parse_and_pixel_address_top dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // parser state and limits as the block should hold them
  logic [15:0] lim_w = bhp_pkg::RST_MAX_WIDTH;
  logic [15:0] lim_h = bhp_pkg::RST_MAX_HEIGHT;
  logic [31:0] lim_isize = bhp_pkg::RST_MAX_ISIZE;
  logic [5:0]  hdr_pos = '0;
  logic        hdr_bad = 1'b0;
  logic [15:0] sig_r = '0;
  logic [31:0] offset_r = '0;
  logic [31:0] dib_r = '0;
  logic [31:0] raw_w_r = '0;
  logic [31:0] raw_h_r = '0;
  logic [15:0] bpp_r = '0;
  logic [31:0] comp_r = '0;
  logic [31:0] isize_r = '0;
  logic [17:0] stride_r = '0;

  result_t     awaited_q[$];
  logic [7:0]  file_head [HDR_LEN];

  int          send_idle_pct = 21;
  int          recv_idle_pct = 53;
  logic        hold_toggle = 1'b0;
  logic        hold_seen;
  int          hold_left;
  int          cycle_cnt = 0;
  int          items_taken = 0;
  int          verdicts_seen = 0;
  int          addresses_seen = 0;
  int          fail_cnt = 0;
  int          result_idx = 0;

  function automatic logic [31:0] merge_le(logic [31:0] field, int pos, int start, int len,
                                           logic [7:0] d);
    if (pos >= start && pos < start + len) field[(pos - start) * 8 +: 8] = d;
    return field;
  endfunction

  // returns 1 unless the item was ignored
  function automatic logic parse_and_address(logic req, logic [7:0] d, logic first,
                                             logic [15:0] x, logic [15:0] y);
    result_t     r;
    int          pos;
    logic [31:0] aw, ah, three_w;
    logic [1:0]  pad;
    logic        bad;
    r = '0;
    if (req == REQ_QUERY) begin
      r.kind = bhp_pkg::KIND_PIX;
      r.pixel_offset = 34'(64'(x) * 64'd3 + 64'(stride_r) * 64'(y));
      awaited_q.push_back(r);
      return 1'b1;
    end
    if (first) begin
      hdr_pos = '0;
      hdr_bad = 1'b0;
      sig_r = '0;
      offset_r = '0;
      dib_r = '0;
      raw_w_r = '0;
      raw_h_r = '0;
      bpp_r = '0;
      comp_r = '0;
      isize_r = '0;
      stride_r = '0;
    end
    if (hdr_bad || hdr_pos >= bhp_pkg::HDR_BYTES) return 1'b0;
    pos = int'(hdr_pos);
    sig_r    = 16'(merge_le({16'd0, sig_r}, pos, bhp_pkg::OFS_SIG, 2, d));
    offset_r = merge_le(offset_r, pos, bhp_pkg::OFS_DATA, 4, d);
    dib_r    = merge_le(dib_r, pos, bhp_pkg::OFS_DIB, 4, d);
    raw_w_r  = merge_le(raw_w_r, pos, bhp_pkg::OFS_WIDTH, 4, d);
    raw_h_r  = merge_le(raw_h_r, pos, bhp_pkg::OFS_HEIGHT, 4, d);
    bpp_r    = 16'(merge_le({16'd0, bpp_r}, pos, bhp_pkg::OFS_BPP, 2, d));
    comp_r   = merge_le(comp_r, pos, bhp_pkg::OFS_COMP, 4, d);
    isize_r  = merge_le(isize_r, pos, bhp_pkg::OFS_ISIZE, 4, d);
    hdr_pos = hdr_pos + 6'd1;
    if (hdr_pos == 6'(bhp_pkg::FILE_HDR_BYTES)) begin
      if (sig_r != bhp_pkg::SIG_BM) begin
        hdr_bad = 1'b1;
        r.kind = bhp_pkg::KIND_HDR;
        r.status = bhp_pkg::ST_BAD_FILE;
        r.data_offset = offset_r;
        awaited_q.push_back(r);
      end
    end else if (hdr_pos == bhp_pkg::HDR_BYTES) begin
      aw = raw_w_r[31] ? 32'd0 - raw_w_r : raw_w_r;
      ah = raw_h_r[31] ? 32'd0 - raw_h_r : raw_h_r;
      bad = dib_r < bhp_pkg::MIN_DIB_SIZE || aw > {16'd0, lim_w} || ah > {16'd0, lim_h} ||
            isize_r > lim_isize || bpp_r != bhp_pkg::BPP_24 || comp_r != 32'd0;
      r.kind = bhp_pkg::KIND_HDR;
      r.data_offset = offset_r;
      r.image_size = isize_r;
      if (bad) begin
        r.status = bhp_pkg::ST_BAD_INFO;
      end else begin
        three_w = aw * 32'd3;
        pad = (three_w[1:0] == 2'd0) ? 2'd0 : 2'(3'd4 - {1'b0, three_w[1:0]});
        stride_r = 18'(three_w + 32'(pad));
        r.status = bhp_pkg::ST_OK;
        r.width = aw[15:0];
        r.height = ah[15:0];
        r.row_bytes = stride_r;
        r.padding = pad;
      end
      awaited_q.push_back(r);
    end
    return 1'b1;
  endfunction

  function automatic void put_le(int start, int len, logic [31:0] val);
    for (int k = 0; k < len; k++) file_head[start + k] = val[8 * k +: 8];
  endfunction

  function automatic void build_header(logic [15:0] sig, logic [31:0] ofs, logic [31:0] dib,
                                       logic [31:0] w, logic [31:0] h, logic [15:0] bpp,
                                       logic [31:0] comp, logic [31:0] isz);
    for (int i = 0; i < HDR_LEN; i++) file_head[i] = 8'($urandom);
    put_le(bhp_pkg::OFS_SIG, 2, {16'd0, sig});
    put_le(bhp_pkg::OFS_DATA, 4, ofs);
    put_le(bhp_pkg::OFS_DIB, 4, dib);
    put_le(bhp_pkg::OFS_WIDTH, 4, w);
    put_le(bhp_pkg::OFS_HEIGHT, 4, h);
    put_le(bhp_pkg::OFS_BPP, 2, {16'd0, bpp});
    put_le(bhp_pkg::OFS_COMP, 4, comp);
    put_le(bhp_pkg::OFS_ISIZE, 4, isz);
  endfunction

  function automatic void good_header(logic [31:0] w, logic [31:0] h, logic [31:0] isz);
    build_header(bhp_pkg::SIG_BM, 32'd54, bhp_pkg::MIN_DIB_SIZE, w, h, bhp_pkg::BPP_24,
                 32'd0, isz);
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(3))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_item(input logic req, input logic [7:0] d, input logic first,
                           input logic [15:0] x, input logic [15:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {7'd0, y, x, first, d};
    do @(posedge clk); while (!s_tready);
    if (parse_and_address(req, d, first, x, y)) items_taken++;
  endtask

  task automatic send_query(input logic [15:0] x, input logic [15:0] y);
    send_item(REQ_QUERY, 8'($urandom), 1'($urandom), x, y);
  endtask

  task automatic send_header(input int n, input logic start);
    for (int i = 0; i < n; i++)
      send_item(REQ_BYTE, file_head[i], (i == 0) ? start : 1'b0, 16'($urandom), 16'($urandom));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (awaited_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      bhp_pkg::REG_MAX_WIDTH:  lim_w = val[15:0];
      bhp_pkg::REG_MAX_HEIGHT: lim_h = val[15:0];
      bhp_pkg::REG_MAX_ISIZE:  lim_isize = val;
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [15:0] w, input logic [15:0] h, input logic [31:0] isz);
    wait_idle();
    write_reg(bhp_pkg::REG_MAX_WIDTH, {16'd0, w});
    write_reg(bhp_pkg::REG_MAX_HEIGHT, {16'd0, h});
    write_reg(bhp_pkg::REG_MAX_ISIZE, isz);
    cfg_valid <= 1'b0;
  endtask

  // stride is still zero: answers are 3*x
  task automatic test_query_no_header();
    send_query(16'd0, 16'd0);
    send_query(16'hFFFF, 16'hFFFF);
    send_query(rand_coord(), rand_coord());
  endtask

  // bytes counted from zero after reset without a start flag, then ignored past the end
  task automatic test_header_no_start();
    good_header(32'd5, 32'd3, 32'd48);
    send_header(HDR_LEN, 1'b0);
    send_query(16'hFFFF, 16'hFFFF);
    send_query(16'd4, 16'd2);
    send_item(REQ_BYTE, 8'hFF, 1'b0, 16'd0, 16'd0);
    send_item(REQ_BYTE, 8'h00, 1'b0, 16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_bad_signature();
    build_header(16'h4D43, 32'hFFFF_FFFF, bhp_pkg::MIN_DIB_SIZE, 32'd4, 32'd4,
                 bhp_pkg::BPP_24, 32'd0, 32'd0);
    send_header(bhp_pkg::FILE_HDR_BYTES + 2, 1'b1);
    send_query(16'd7, 16'd9);
  endtask

  task automatic test_restart();
    good_header(32'd7, 32'd2, 32'd0);
    send_header(16, 1'b1);
    good_header(32'd2, -32'sd9, 32'd100);
    send_header(HDR_LEN, 1'b1);
    send_query(16'd1, 16'd1);
  endtask

  task automatic test_most_negative();
    good_header(32'h8000_0000, 32'd3, 32'd0);
    send_header(HDR_LEN, 1'b1);
    good_header(32'd3, 32'h8000_0000, 32'd0);
    send_header(HDR_LEN, 1'b1);
  endtask

  task automatic test_limit_extremes();
    set_limits(16'd1, 16'd1, 32'd0);
    good_header(32'd1, 32'd1, 32'd0);
    send_header(HDR_LEN, 1'b1);
    send_query(16'hFFFF, 16'hFFFF);
    set_limits(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    good_header(32'd65535, -32'sd65535, 32'hFFFF_FFFF);
    send_header(HDR_LEN, 1'b1);
    send_query(16'hFFFF, 16'hFFFF);
    set_limits(bhp_pkg::RST_MAX_WIDTH, bhp_pkg::RST_MAX_HEIGHT, bhp_pkg::RST_MAX_ISIZE);
  endtask

  // receiver holds off while queries keep coming, so the block has to stall its input
  task automatic test_backpressure();
    int saved_pct;
    wait_idle();
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    hold_toggle <= ~hold_toggle;
    repeat (16) send_query(rand_coord(), rand_coord());
    send_idle_pct = saved_pct;
    wait_idle();
  endtask

  task automatic random_header();
    defect_t     flaw;
    logic [15:0] sig, bpp;
    logic [31:0] w, h, isz, dib, comp;
    int          len;
    logic        start;
    flaw = ($urandom_range(99) < 50) ? DEF_NONE : defect_t'($urandom_range(DEF_SIG, DEF_TRUNC));
    sig = bhp_pkg::SIG_BM;
    dib = ($urandom_range(3) == 0) ? 32'($urandom) | bhp_pkg::MIN_DIB_SIZE
                                   : bhp_pkg::MIN_DIB_SIZE + $urandom_range(0, 84);
    w = $urandom_range(0, lim_w);
    h = $urandom_range(0, lim_h);
    if ($urandom_range(3) == 0) w = 32'd0 - w;
    if ($urandom_range(1) == 0) h = 32'd0 - h;
    bpp = bhp_pkg::BPP_24;
    comp = 32'd0;
    isz = $urandom_range(0, lim_isize);
    len = HDR_LEN;
    case (flaw)
      DEF_SIG: begin
        sig = 16'($urandom);
        if (sig == bhp_pkg::SIG_BM) sig = sig ^ 16'h0100;
      end
      DEF_DIB:    dib = $urandom_range(0, bhp_pkg::MIN_DIB_SIZE - 1);
      DEF_WIDTH:  w = ($urandom_range(3) == 0) ? 32'h8000_0000
                                               : 32'(lim_w) + $urandom_range(1, 70000);
      DEF_HEIGHT: h = ($urandom_range(3) == 0) ? 32'h8000_0000
                                               : 32'd0 - (32'(lim_h) + $urandom_range(1, 70000));
      DEF_ISIZE:  isz = lim_isize + $urandom_range(1, 1000);
      DEF_BPP: begin
        bpp = 16'($urandom);
        if (bpp == bhp_pkg::BPP_24) bpp = 16'd32;
      end
      DEF_COMP:   comp = $urandom_range(1, 32'hFFFF_FFFF);
      DEF_TRUNC:  len = $urandom_range(1, HDR_LEN - 1);
      default: ;
    endcase
    start = ($urandom_range(9) != 0);
    build_header(sig, 32'($urandom), dib, w, h, bpp, comp, isz);
    send_header(len, start);
  endtask

  task automatic test_random(input int n_items, input int tx_pct, input int rx_pct);
    int stop_at;
    int pick;
    set_limits(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
               ($urandom_range(3) == 0) ? 32'($urandom) : $urandom_range(0, 1 << 22));
    send_idle_pct = tx_pct;
    recv_idle_pct = rx_pct;
    stop_at = items_taken + n_items;
    while (items_taken < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        random_header();
        repeat ($urandom_range(0, 4)) send_query(rand_coord(), rand_coord());
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 6))
          send_item(REQ_BYTE, 8'($urandom), ($urandom_range(7) == 0), 16'($urandom),
                    16'($urandom));
      end else begin
        repeat ($urandom_range(1, 6)) send_query(rand_coord(), rand_coord());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_seen <= 1'b0;
      hold_left <= 0;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [33:0] want, input logic [33:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= 10)
        $display("result %0d %s: expected %0h, got %0h", result_idx, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (awaited_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10) $display("result %0d arrived with none pending: %h", result_idx, got);
      end else begin
        want = awaited_q.pop_front();
        check_field("kind", 34'(want.kind), 34'(got.kind));
        check_field("status", 34'(want.status), 34'(got.status));
        check_field("width", 34'(want.width), 34'(got.width));
        check_field("height", 34'(want.height), 34'(got.height));
        check_field("row_bytes", 34'(want.row_bytes), 34'(got.row_bytes));
        check_field("padding", 34'(want.padding), 34'(got.padding));
        check_field("data_offset", 34'(want.data_offset), 34'(got.data_offset));
        check_field("image_size", 34'(want.image_size), 34'(got.image_size));
        check_field("pixel_offset", want.pixel_offset, got.pixel_offset);
        if (want.kind == bhp_pkg::KIND_PIX) addresses_seen++;
        else verdicts_seen++;
      end
      result_idx++;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt, awaited_q.size());
      $display("bmp_header_parse_and_pixel_address_top test failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_query_no_header();
    test_header_no_start();
    test_bad_signature();
    test_restart();
    test_most_negative();
    test_limit_extremes();
    test_random(20, 21, 53);
    test_backpressure();
    test_random(20, 53, 21);
    test_random(20, 0, 0);
    wait_idle();
    $display("Ran %0d accepted items: %0d header verdicts and %0d pixel addresses checked,",
             items_taken, verdicts_seen, addresses_seen);
    $display("across limit extremes, restarts, broken headers and a long output stall.");
    if (fail_cnt == 0 && awaited_q.size() == 0) begin
      $display("bmp_header_parse_and_pixel_address_top test passed");
    end else begin
      $display("%0d failures, %0d results never arrived", fail_cnt, awaited_q.size());
      $display("bmp_header_parse_and_pixel_address_top test failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+design
design/bhp_pkg.sv
design/bhp_front.sv
design/bhp_queue.sv
design/bhp_back.sv
design/bmp_header_parse_and_pixel_address_top.sv
design/bhp_checker.sv
tb/tb_bmp_header_parse_and_pixel_address_top.sv
